[src/nclc_pkg.sv]
// ----------------------------------------------------------------------------
// nclc_pkg
// Shared types and constants for the nearest-center leader clustering core.
// ----------------------------------------------------------------------------
`default_nettype none

package nclc_pkg;

  localparam int unsigned MaxClustersDef = 64;
  localparam int unsigned CoordW         = 16;
  localparam int unsigned IndexW         = 6;
  localparam int unsigned ThreshW        = 16;
  localparam int unsigned SqW            = 2 * CoordW;
  localparam int unsigned DistW          = SqW + 1;

  // Reset value of the threshold: 2.0 in unsigned Q8.8.
  localparam logic [ThreshW-1:0] ThreshReset = 16'd512;

  typedef struct packed {
    logic signed [CoordW-1:0] point_size;
    logic signed [CoordW-1:0] point_speed;
  } point_t;

  typedef struct packed {
    logic [IndexW-1:0] cluster_index;
    logic              created_new;
    logic              table_full;
  } result_t;

  localparam int unsigned PointW = $bits(point_t);

endpackage

`default_nettype wire

[src/nclc_ram.sv]
// ----------------------------------------------------------------------------
// nclc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nclc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/nclc_dist.sv]
// ----------------------------------------------------------------------------
// nclc_dist
// Three-stage squared Euclidean distance pipeline: difference, square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nclc_dist
  import nclc_pkg::*;
#(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic             last_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire point_t           center_i,
  input  wire point_t           point_i,
  output logic                  vld_o,
  output logic                  last_o,
  output logic      [IDX_W-1:0] idx_o,
  output logic      [DistW-1:0] dist_o
);

  localparam int unsigned ProdW = 2 * CoordW + 2;

  logic [2:0]             vld_q;
  logic [2:0]             last_q;
  logic [IDX_W-1:0]       idx1_q, idx2_q, idx3_q;
  logic signed [CoordW:0] dsz_q, dsp_q;
  logic [SqW-1:0]         sqz_q, sqp_q;
  logic [DistW-1:0]       dist_q;

  logic signed [CoordW:0]  dsz_d, dsp_d;
  logic signed [ProdW-1:0] prodz, prodp;

  always_comb begin
    dsz_d = {center_i.point_size[CoordW-1], center_i.point_size}
          - {point_i.point_size[CoordW-1], point_i.point_size};
    dsp_d = {center_i.point_speed[CoordW-1], center_i.point_speed}
          - {point_i.point_speed[CoordW-1], point_i.point_speed};
    prodz = ProdW'(dsz_q) * ProdW'(dsz_q);
    prodp = ProdW'(dsp_q) * ProdW'(dsp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      last_q <= '0;
    end else begin
      vld_q  <= {vld_q[1:0], vld_i};
      last_q <= {last_q[1:0], last_i};
    end
  end

  // The squares of a 17-bit difference never exceed 32 unsigned bits.
  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    dsz_q  <= dsz_d;
    dsp_q  <= dsp_d;
    idx2_q <= idx1_q;
    sqz_q  <= prodz[SqW-1:0];
    sqp_q  <= prodp[SqW-1:0];
    idx3_q <= idx2_q;
    dist_q <= {1'b0, sqz_q} + {1'b0, sqp_q};
  end

  assign vld_o  = vld_q[2];
  assign last_o = last_q[2];
  assign idx_o  = idx3_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

[src/nearest_center_leader_clustering_core.sv]
// ----------------------------------------------------------------------------
// nearest_center_leader_clustering_core
// Finds the nearest stored cluster center for each point, or appends the
// point as a new center when none lies within the distance threshold.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Word
//  in        input      in_valid_i/in_ready_o   point_t (size, speed)
//  out       output     out_valid_o/out_ready_i result_t (index, new, full)
//  cfg       input      cfg_we_i                distance threshold, Q8.8
//
//  A point with n stored centers is accepted, then the n centers stream out of
//  the center RAM through its single read port, pass through the RAM read
//  register and the three distance pipeline stages, and the core decides and
//  appends. Reset empties the table and sets the threshold to 2.0.
//  The result waits in an output register; a stalled output only holds the
//  decide step, and the next point is taken as soon as that result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_center_leader_clustering_core
  import nclc_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = MaxClustersDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire point_t             in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output result_t                 out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [ThreshW-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StDecide
  } state_e;

  state_e             state_q;
  logic [ThreshW-1:0] thresh_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   n_q;
  logic [IDX_W-1:0]   rd_cnt_q;
  point_t             point_q;
  logic [SqW-1:0]     thr_sq_q;
  logic [DistW-1:0]   best_d_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               out_valid_q;
  result_t            out_data_q;

  logic               in_acc;
  logic               rd_en;
  logic               rd_last;
  logic               s0_vld_q, s0_last_q;
  logic [IDX_W-1:0]   s0_idx_q;
  logic [PointW-1:0]  rdata;
  logic               d_vld, d_last;
  logic [IDX_W-1:0]   d_idx;
  logic [DistW-1:0]   d_dist;
  logic               matched, has_room, out_free, finish, wr_en;
  result_t            res_d;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_en      = (state_q == StScan);
  assign rd_last    = (CNT_W'(rd_cnt_q) + CNT_W'(1) == n_q);

  nclc_ram #(
    .WIDTH (PointW),
    .DEPTH (MAX_CLUSTERS)
  ) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (n_q[IDX_W-1:0]),
    .wdata_i (point_q),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q),
    .rdata_o (rdata)
  );

  nclc_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (s0_vld_q),
    .last_i   (s0_last_q),
    .idx_i    (s0_idx_q),
    .center_i (point_t'(rdata)),
    .point_i  (point_q),
    .vld_o    (d_vld),
    .last_o   (d_last),
    .idx_o    (d_idx),
    .dist_o   (d_dist)
  );

  // An empty table never matches, so the first point always becomes center 0.
  always_comb begin
    matched  = (n_q != '0) && (best_d_q < {1'b0, thr_sq_q});
    has_room = (n_q < CNT_W'(MAX_CLUSTERS));
    out_free = !out_valid_q || out_ready_i;
    finish   = (state_q == StDecide) && out_free;
    wr_en    = finish && !matched && has_room;
    res_d    = '0;
    if (matched) begin
      res_d.cluster_index = IndexW'(best_idx_q);
    end else if (has_room) begin
      res_d.cluster_index = IndexW'(n_q);
      res_d.created_new   = 1'b1;
    end else begin
      res_d.cluster_index = IndexW'(best_idx_q);
      res_d.table_full    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      thresh_q    <= ThreshReset;
      count_q     <= '0;
      s0_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      s0_vld_q <= rd_en;
      if (finish) begin
        out_valid_q <= 1'b1;
        out_data_q  <= res_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= (count_q == '0) ? StDecide : StScan;
          end
        end
        StScan: begin
          if (rd_last) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (d_vld && d_last) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (out_free) begin
            state_q <= StIdle;
            if (wr_en) begin
              count_q <= n_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      point_q  <= in_data_i;
      n_q      <= count_q;
      thr_sq_q <= SqW'(thresh_q) * SqW'(thresh_q);
      rd_cnt_q <= '0;
    end else if (rd_en) begin
      rd_cnt_q <= rd_cnt_q + IDX_W'(1);
    end
    s0_idx_q  <= rd_cnt_q;
    s0_last_q <= rd_last;
    // Strict less-than keeps the lowest index on a tie.
    if (d_vld && ((d_idx == '0) || (d_dist < best_d_q))) begin
      best_d_q   <= d_dist;
      best_idx_q <= d_idx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-center leader clustering core. Points
// go in through a bursty sender and results come out through a receiver that
// stalls at random. A behavioral copy of the center table predicts every
// result word, and results are checked in order, field by field. The bench
// walks the threshold through several settings, including zero and the
// maximum, and runs the table until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import nclc_pkg::*;

  localparam int unsigned NumCenters = MaxClustersDef;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxShown   = 10;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready_o;
  point_t              in_data   = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  result_t             out_data_o;
  logic                cfg_we    = 1'b0;
  logic [ThreshW-1:0]  cfg_wdata = '0;

  // Behavioral copy of the block state.
  logic signed [CoordW-1:0] center_size_q  [NumCenters];
  logic signed [CoordW-1:0] center_speed_q [NumCenters];
  int unsigned              stored_count = 0;
  logic [ThreshW-1:0]       threshold_q  = ThreshReset;

  result_t     expected_results [$];
  int unsigned error_count   = 0;
  int unsigned points_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned full_results  = 0;
  int unsigned burst_left    = 0;
  int unsigned ready_hold    = 0;
  int unsigned cycle_count   = 0;

  nearest_center_leader_clustering_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Nearest-center search with append, updating the table copy.
  function automatic result_t predict_cluster(input point_t p);
    longint unsigned thr_sq;
    longint unsigned best_d;
    longint unsigned d;
    longint          ds;
    longint          dv;
    int unsigned     best;
    result_t         r;
    thr_sq = longint'(threshold_q) * longint'(threshold_q);
    best   = 0;
    best_d = 0;
    r      = '0;
    for (int unsigned i = 0; i < stored_count; i++) begin
      ds = longint'(center_size_q[i]) - longint'(p.point_size);
      dv = longint'(center_speed_q[i]) - longint'(p.point_speed);
      d  = ds * ds + dv * dv;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    if (stored_count > 0 && best_d < thr_sq) begin
      r.cluster_index = IndexW'(best);
    end else if (stored_count < NumCenters) begin
      center_size_q[stored_count]  = p.point_size;
      center_speed_q[stored_count] = p.point_speed;
      r.cluster_index = IndexW'(stored_count);
      r.created_new   = 1'b1;
      stored_count++;
    end else begin
      r.cluster_index = IndexW'(best);
      r.table_full    = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] extreme_coord();
    logic [CoordW-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'h0000;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // Mostly points near a stored center, so both sides of the threshold are
  // hit, plus extremes and plain noise.
  function automatic point_t random_point();
    point_t      p;
    int unsigned roll;
    int unsigned c;
    int unsigned reach;
    int          off_s;
    int          off_v;
    roll          = $urandom_range(0, 99);
    p.point_size  = CoordW'($urandom);
    p.point_speed = CoordW'($urandom);
    if (stored_count == 0 || roll >= 85) begin
      return p;
    end
    if (roll >= 75) begin
      p.point_size  = extreme_coord();
      p.point_speed = extreme_coord();
      return p;
    end
    c     = $urandom_range(0, stored_count - 1);
    reach = int'(threshold_q) + 64;
    if (reach > 40000) reach = 40000;
    if (roll < 12) begin
      // Exactly on the threshold along one axis.
      off_s = ($urandom_range(0, 1) != 0) ? int'(threshold_q) : -int'(threshold_q);
      off_v = 0;
    end else begin
      off_s = int'($urandom_range(0, 2 * reach)) - int'(reach);
      off_v = int'($urandom_range(0, 2 * reach)) - int'(reach);
    end
    p.point_size  = CoordW'(int'(center_size_q[c]) + off_s);
    p.point_speed = CoordW'(int'(center_speed_q[c]) + off_v);
    return p;
  endfunction

  // Valid stays high across a burst; it only drops for a gap.
  task automatic send_point(input point_t p);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_cluster(p));
    points_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 90) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_coords(input int s, input int v);
    point_t p;
    p.point_size  = CoordW'(s);
    p.point_speed = CoordW'(v);
    send_point(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThreshW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    threshold_q  = v;
  endtask

  task automatic run_phase(input logic [ThreshW-1:0] thr, input int unsigned count);
    drain_results();
    write_threshold(thr);
    repeat (count) send_point(random_point());
  endtask

  // Reset threshold on an empty table, then the boundary and tie cases.
  task automatic test_default_threshold();
    send_coords(-32768, -32768);
    send_coords(-32768, -32768);
    send_coords(32767, 32767);
    send_coords(-32768 + 512, -32768);
    send_coords(-32768 + 256, -32768);
    send_coords(-32768 + 511, -32768);
    send_coords(0, 0);
    send_coords(0, -1);
    send_coords(32767, -32768);
    send_coords(-32768, 32767);
  endtask

  task automatic test_max_threshold();
    drain_results();
    write_threshold(16'hFFFF);
    send_coords(256, 256);
    send_coords(32767, -32768);
    send_coords(0, 32767);
  endtask

  // With a zero threshold even exact duplicates become new centers.
  task automatic test_zero_threshold();
    drain_results();
    write_threshold(16'h0000);
    send_coords(0, 0);
    send_coords(32767, 32767);
    send_coords(-1, 1);
  endtask

  task automatic test_random_filling();
    run_phase(16'h6000, 100);
    run_phase(16'h2000, 100);
    run_phase(ThreshW'($urandom), 100);
    run_phase(16'h0800, 100);
  endtask

  // A zero threshold fills whatever is left, then the table stays full.
  task automatic test_full_table();
    run_phase(16'h0000, 100);
    run_phase(16'hFFFF, 110);
    run_phase(16'h0001, 110);
    run_phase(ThreshW'($urandom), 110);
  endtask

  // The receiver mixes long ready stretches, long stalls and choppy spells.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(50, 300);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(1, 40);
      end else begin
        out_ready  <= ($urandom_range(0, 1) != 0);
        ready_hold <= $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxShown) begin
          $display("Result word with nothing expected: index %0d new %b full %b",
                   out_data_o.cluster_index, out_data_o.created_new,
                   out_data_o.table_full);
        end
      end else begin
        want = expected_results.pop_front();
        if (want.table_full) full_results++;
        if (out_data_o.cluster_index !== want.cluster_index ||
            out_data_o.created_new !== want.created_new ||
            out_data_o.table_full !== want.table_full) begin
          error_count++;
          if (error_count <= MaxShown) begin
            $display("Mismatch on result %0d: index %0d/%0d new %b/%b full %b/%b (got/want)",
                     results_seen, out_data_o.cluster_index, want.cluster_index,
                     out_data_o.created_new, want.created_new,
                     out_data_o.table_full, want.table_full);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_threshold();
    test_max_threshold();
    test_zero_threshold();
    test_random_filling();
    test_full_table();
    drain_results();
    repeat (NumCenters + 16) @(posedge clk_i);
    $display("Checked %0d results for %0d points across eleven threshold settings.",
             results_seen, points_sent);
    $display("The table ended with %0d centers; %0d results reported it full.",
             stored_count, full_results);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[nearest_center_leader_clustering_core.f]
src/nclc_pkg.sv
src/nclc_ram.sv
src/nclc_dist.sv
src/nearest_center_leader_clustering_core.sv
sim/testbench.sv
